>>> hw/rtl/expression_syntax_validator_assert.svh
// Assertion macros used by the checker file of the expression syntax validator.
`ifndef EXPRESSION_SYNTAX_VALIDATOR_ASSERT_SVH
`define EXPRESSION_SYNTAX_VALIDATOR_ASSERT_SVH
// Concurrent check on clk, switched off while rst_n is low.
`define ESV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Concurrent check on clk that also runs through reset.
`define ESV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hw/rtl/esv_pkg.sv
// Types, constants and character decoders of the expression syntax validator.
package esv_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int STACK_DEPTH = 64;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CC_W        = $clog2(MAX_LEN + 1);
  localparam int POS_W       = 13;
  localparam int CH_W        = 8;

  // Position reported for a character beyond the length limit, masked to the field
  localparam logic [POS_W-1:0] POS_OVF = POS_W'(MAX_LEN + 1);

  localparam logic [CH_W-1:0] CH_NONE   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_LSQ    = 8'h5B;
  localparam logic [CH_W-1:0] CH_RSQ    = 8'h5D;
  localparam logic [CH_W-1:0] CH_LCURLY = 8'h7B;
  localparam logic [CH_W-1:0] CH_RCURLY = 8'h7D;

  localparam logic [1:0] LVL_NONE    = 2'd0;
  localparam logic [1:0] LVL_CHARS   = 2'd1;
  localparam logic [1:0] LVL_BRACKET = 2'd2;
  localparam logic [1:0] LVL_STRUCT  = 2'd3;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_BAD_CHAR  = 4'd1;
  localparam logic [3:0] ERR_NO_OPEN   = 4'd2;
  localparam logic [3:0] ERR_MISMATCH  = 4'd3;
  localparam logic [3:0] ERR_UNCLOSED  = 4'd4;
  localparam logic [3:0] ERR_TWO_NUMS  = 4'd5;
  localparam logic [3:0] ERR_OP_START  = 4'd6;
  localparam logic [3:0] ERR_TWO_OPS   = 4'd7;
  localparam logic [3:0] ERR_OP_OPEN   = 4'd8;
  localparam logic [3:0] ERR_EMPTY_GRP = 4'd9;
  localparam logic [3:0] ERR_EMPTY     = 4'd10;
  localparam logic [3:0] ERR_OP_END    = 4'd11;
  localparam logic [3:0] ERR_CAPACITY  = 4'd12;

  typedef enum logic [1:0] {
    TK_NUM   = 2'd0,
    TK_OP    = 2'd1,
    TK_OPEN  = 2'd2,
    TK_CLOSE = 2'd3
  } tok_kind_t;

  typedef enum logic [1:0] {
    BK_PAREN  = 2'd0,
    BK_SQUARE = 2'd1,
    BK_CURLY  = 2'd2
  } brk_t;

  typedef struct packed {
    brk_t             kind;
    logic [POS_W-1:0] pos;
  } stk_ent_t;

  typedef struct packed {
    logic             vld;
    logic [3:0]       code;
    logic [POS_W-1:0] pos;
    logic [CH_W-1:0]  found;
    logic [CH_W-1:0]  expected;
    logic [POS_W-1:0] opener;
  } err_rec_t;

  typedef struct packed {
    logic             accepted;
    logic [1:0]       failed_level;
    logic [3:0]       error_code;
    logic [POS_W-1:0] position;
    logic [CH_W-1:0]  found_char;
    logic [CH_W-1:0]  expected_char;
    logic [POS_W-1:0] opener_position;
  } result_t;

  function automatic logic is_digit(logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_op(logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic logic is_ws(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_opener(logic [CH_W-1:0] c);
    return (c == CH_LPAREN) || (c == CH_LSQ) || (c == CH_LCURLY);
  endfunction

  function automatic logic is_closer(logic [CH_W-1:0] c);
    return (c == CH_RPAREN) || (c == CH_RSQ) || (c == CH_RCURLY);
  endfunction

  function automatic logic is_legal(logic [CH_W-1:0] c);
    return is_digit(c) || is_op(c) || is_opener(c) || is_closer(c) || is_ws(c);
  endfunction

  // Bracket family of an opener or a closer
  function automatic brk_t bkind(logic [CH_W-1:0] c);
    brk_t k;
    unique case (c) inside
      CH_LSQ, CH_RSQ:       k = BK_SQUARE;
      CH_LCURLY, CH_RCURLY: k = BK_CURLY;
      default:              k = BK_PAREN;
    endcase
    return k;
  endfunction

  function automatic logic [CH_W-1:0] closer_of(brk_t k);
    logic [CH_W-1:0] c;
    unique case (k)
      BK_SQUARE: c = CH_RSQ;
      BK_CURLY:  c = CH_RCURLY;
      default:   c = CH_RPAREN;
    endcase
    return c;
  endfunction

  function automatic err_rec_t mk_err(logic [3:0] code, logic [POS_W-1:0] pos,
                                      logic [CH_W-1:0] found, logic [CH_W-1:0] expected,
                                      logic [POS_W-1:0] opener);
    err_rec_t e;
    e.vld      = 1'b1;
    e.code     = code;
    e.pos      = pos;
    e.found    = found;
    e.expected = expected;
    e.opener   = opener;
    return e;
  endfunction

  function automatic result_t to_result(logic [1:0] lvl, err_rec_t e);
    result_t r;
    r.accepted        = 1'b0;
    r.failed_level    = lvl;
    r.error_code      = e.code;
    r.position        = e.pos;
    r.found_char      = e.found;
    r.expected_char   = e.expected;
    r.opener_position = e.opener;
    return r;
  endfunction

endpackage

>>> hw/rtl/esv_if.sv
// Request and result channel interfaces of the expression syntax validator.
interface esv_in_if;
  logic                    valid;
  logic                    ready;
  logic [esv_pkg::CH_W-1:0] ch;
  logic                    has_char;
  logic                    last;

  modport source (output valid, ch, has_char, last, input ready);
  modport sink   (input valid, ch, has_char, last, output ready);
  modport monitor (input valid, ready, ch, has_char, last);
endinterface

interface esv_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [1:0]                failed_level;
  logic [3:0]                error_code;
  logic [esv_pkg::POS_W-1:0] position;
  logic [esv_pkg::CH_W-1:0]  found_char;
  logic [esv_pkg::CH_W-1:0]  expected_char;
  logic [esv_pkg::POS_W-1:0] opener_position;

  modport source (output valid, accepted, failed_level, error_code, position, found_char,
                  expected_char, opener_position, input ready);
  modport sink   (input valid, accepted, failed_level, error_code, position, found_char,
                  expected_char, opener_position, output ready);
  modport monitor (input valid, ready, accepted, failed_level, error_code, position,
                   found_char, expected_char, opener_position);
endinterface

>>> hw/rtl/esv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module esv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/expression_syntax_validator.sv
// Top level of the expression syntax validator.
// Usage: an expression arrives on in_req one request per character (ch with
// has_char high); the request with last high closes it, and has_char low with
// last high marks an empty expression or an end without a character.
// Every closed expression yields one request on out_res: accepted, or the
// first error of the lowest failing level (characters, brackets, structure).
// Throughput: one character per cycle, set by the bracket stack top, which is
// read, modified and written back through a registered-read RAM with a
// write-to-read bypass; back-to-back expressions keep that rate while the
// result queue has room for each closing request. The closing request is
// captured into the finishing stage, which reads the stack top for the
// unclosed check, and its result then passes into the result queue.
// Stall: results wait in a two-entry queue; characters keep flowing, and only
// a closing request is held back while the queue has no room for its result.
// Reset: synchronous rst_n clears counters, token state, error records and the
// queue at once; stack entries are always written before they are read, so no
// clearing pass is needed.
module expression_syntax_validator (
  input  logic clk,
  input  logic rst_n,
  esv_in_if.sink    in_req,
  esv_out_if.source out_res
);

  localparam int STK_W = $bits(esv_pkg::stk_ent_t);

  // live expression state
  logic [esv_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [esv_pkg::CC_W-1:0]  cc_r, cc_nxt;
  esv_pkg::tok_kind_t        kind_r, kind_nxt;
  logic                      seen_r, seen_nxt;
  logic                      innum_r, innum_nxt;
  logic [esv_pkg::POS_W-1:0] ltok_pos_r, ltok_pos_nxt;
  logic [esv_pkg::CH_W-1:0]  ltok_ch_r, ltok_ch_nxt;
  esv_pkg::err_rec_t         err1_r, err1_nxt;
  esv_pkg::err_rec_t         err2_r, err2_nxt;
  esv_pkg::err_rec_t         err3_r, err3_nxt;

  // stack memory and bypass
  logic                      push;
  esv_pkg::stk_ent_t         wdata;
  logic [STK_W-1:0]          rdata;
  logic [esv_pkg::CNT_W-1:0] rd_cnt;
  logic                      byp_sel_r;
  esv_pkg::stk_ent_t         byp_r;
  esv_pkg::stk_ent_t         top;

  // finishing stage
  logic                      fin_vld_r;
  logic                      fin_open_r;
  logic [esv_pkg::POS_W-1:0] fin_len_r;
  esv_pkg::tok_kind_t        fin_kind_r;
  logic                      fin_seen_r;
  logic [esv_pkg::POS_W-1:0] fin_ltok_pos_r;
  logic [esv_pkg::CH_W-1:0]  fin_ltok_ch_r;
  esv_pkg::err_rec_t         fin_err1_r, fin_err2_r, fin_err3_r;
  esv_pkg::err_rec_t         e2f, e3f;
  esv_pkg::result_t          res;

  // result queue
  esv_pkg::result_t          q0_r, q1_r;
  logic [1:0]                qn_r;
  logic [2:0]                occ;
  logic                      pop;
  logic                      acc;
  logic                      clr;

  logic [esv_pkg::CH_W-1:0]  c;
  logic [esv_pkg::POS_W-1:0] pos;

  assign c   = in_req.ch;
  assign acc = in_req.valid && in_req.ready;
  assign clr = acc && in_req.last;
  assign pop = out_res.valid && out_res.ready;
  assign top = byp_sel_r ? byp_r : esv_pkg::stk_ent_t'(rdata);

  // room for one more result once the finishing stage has drained
  assign occ          = 3'(qn_r) + 3'(fin_vld_r) - 3'(pop);
  assign in_req.ready = !in_req.last || (occ <= 3'd1);

  always_comb begin
    cnt_nxt      = cnt_r;
    cc_nxt       = cc_r;
    kind_nxt     = kind_r;
    seen_nxt     = seen_r;
    innum_nxt    = innum_r;
    ltok_pos_nxt = ltok_pos_r;
    ltok_ch_nxt  = ltok_ch_r;
    err1_nxt     = err1_r;
    err2_nxt     = err2_r;
    err3_nxt     = err3_r;
    push         = 1'b0;
    pos          = esv_pkg::POS_W'(cc_r + 1'b1);
    wdata.kind   = esv_pkg::bkind(c);
    wdata.pos    = pos;

    if (acc && in_req.has_char) begin
      if (cc_r >= esv_pkg::CC_W'(esv_pkg::MAX_LEN)) begin
        if (!err1_r.vld) begin
          err1_nxt = esv_pkg::mk_err(esv_pkg::ERR_CAPACITY, esv_pkg::POS_OVF, c,
                                     esv_pkg::CH_NONE, '0);
        end
      end else begin
        cc_nxt = cc_r + 1'b1;

        if (!err1_r.vld && !esv_pkg::is_legal(c)) begin
          err1_nxt = esv_pkg::mk_err(esv_pkg::ERR_BAD_CHAR, pos, c, esv_pkg::CH_NONE, '0);
        end

        if (!err2_r.vld) begin
          if (esv_pkg::is_opener(c)) begin
            if (cnt_r >= esv_pkg::CNT_W'(esv_pkg::STACK_DEPTH)) begin
              err2_nxt = esv_pkg::mk_err(esv_pkg::ERR_CAPACITY, pos, c, esv_pkg::CH_NONE, '0);
            end else begin
              push    = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (esv_pkg::is_closer(c)) begin
            if (cnt_r == '0) begin
              err2_nxt = esv_pkg::mk_err(esv_pkg::ERR_NO_OPEN, pos, c, esv_pkg::CH_NONE, '0);
            end else if (top.kind != esv_pkg::bkind(c)) begin
              err2_nxt = esv_pkg::mk_err(esv_pkg::ERR_MISMATCH, pos, c,
                                         esv_pkg::closer_of(top.kind), '0);
            end else begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end

        if (!err3_r.vld) begin
          if (esv_pkg::is_digit(c)) begin
            // a digit run is one number: only its first digit is a token
            if (!innum_r) begin
              innum_nxt = 1'b1;
              if (seen_r && (kind_r == esv_pkg::TK_NUM)) begin
                err3_nxt = esv_pkg::mk_err(esv_pkg::ERR_TWO_NUMS, pos, c,
                                           esv_pkg::CH_NONE, '0);
              end else begin
                kind_nxt     = esv_pkg::TK_NUM;
                seen_nxt     = 1'b1;
                ltok_pos_nxt = pos;
                ltok_ch_nxt  = c;
              end
            end
          end else begin
            innum_nxt = 1'b0;
            if (esv_pkg::is_op(c)) begin
              if (!seen_r) begin
                err3_nxt = esv_pkg::mk_err(esv_pkg::ERR_OP_START, pos, c,
                                           esv_pkg::CH_NONE, '0);
              end else if (kind_r == esv_pkg::TK_OP) begin
                err3_nxt = esv_pkg::mk_err(esv_pkg::ERR_TWO_OPS, pos, c,
                                           esv_pkg::CH_NONE, '0);
              end else if (kind_r == esv_pkg::TK_OPEN) begin
                err3_nxt = esv_pkg::mk_err(esv_pkg::ERR_OP_OPEN, pos, c,
                                           esv_pkg::CH_NONE, '0);
              end else begin
                kind_nxt     = esv_pkg::TK_OP;
                seen_nxt     = 1'b1;
                ltok_pos_nxt = pos;
                ltok_ch_nxt  = c;
              end
            end else if (esv_pkg::is_opener(c)) begin
              kind_nxt     = esv_pkg::TK_OPEN;
              seen_nxt     = 1'b1;
              ltok_pos_nxt = pos;
              ltok_ch_nxt  = c;
            end else if (esv_pkg::is_closer(c)) begin
              if (!seen_r || (kind_r == esv_pkg::TK_OP) || (kind_r == esv_pkg::TK_OPEN)) begin
                err3_nxt = esv_pkg::mk_err(esv_pkg::ERR_EMPTY_GRP, pos, c,
                                           esv_pkg::CH_NONE, '0);
              end else begin
                kind_nxt     = esv_pkg::TK_CLOSE;
                seen_nxt     = 1'b1;
                ltok_pos_nxt = pos;
                ltok_ch_nxt  = c;
              end
            end
          end
        end
      end
    end

    // fetch the top as it stands after this request, also for the finishing stage
    rd_cnt = cnt_nxt - 1'b1;
  end

  esv_ram #(
    .WIDTH (STK_W),
    .DEPTH (esv_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (cnt_r[esv_pkg::STK_AW-1:0]),
    .wdata (wdata),
    .raddr (rd_cnt[esv_pkg::STK_AW-1:0]),
    .rdata (rdata)
  );

  // a push always lands on the entry that becomes the top, so forward it
  always_ff @(posedge clk) begin
    byp_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cnt_r      <= '0;
      cc_r       <= '0;
      kind_r     <= esv_pkg::TK_NUM;
      seen_r     <= 1'b0;
      innum_r    <= 1'b0;
      ltok_pos_r <= '0;
      ltok_ch_r  <= '0;
      err1_r     <= '0;
      err2_r     <= '0;
      err3_r     <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      cc_r       <= cc_nxt;
      kind_r     <= kind_nxt;
      seen_r     <= seen_nxt;
      innum_r    <= innum_nxt;
      ltok_pos_r <= ltok_pos_nxt;
      ltok_ch_r  <= ltok_ch_nxt;
      err1_r     <= err1_nxt;
      err2_r     <= err2_nxt;
      err3_r     <= err3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_sel_r <= 1'b0;
      fin_vld_r <= 1'b0;
    end else begin
      byp_sel_r <= push;
      fin_vld_r <= clr;
    end
  end

  // capture the closed expression for its end-of-expression checks
  always_ff @(posedge clk) begin
    if (clr) begin
      fin_open_r     <= (cnt_nxt != '0);
      fin_len_r      <= esv_pkg::POS_W'(cc_nxt);
      fin_kind_r     <= kind_nxt;
      fin_seen_r     <= seen_nxt;
      fin_ltok_pos_r <= ltok_pos_nxt;
      fin_ltok_ch_r  <= ltok_ch_nxt;
      fin_err1_r     <= err1_nxt;
      fin_err2_r     <= err2_nxt;
      fin_err3_r     <= err3_nxt;
    end
  end

  always_comb begin
    e2f = fin_err2_r;
    if (!fin_err2_r.vld && fin_open_r) begin
      e2f = esv_pkg::mk_err(esv_pkg::ERR_UNCLOSED, fin_len_r, esv_pkg::CH_NONE,
                            esv_pkg::closer_of(top.kind), top.pos);
    end
    e3f = fin_err3_r;
    if (!fin_err3_r.vld) begin
      if (!fin_seen_r) begin
        e3f = esv_pkg::mk_err(esv_pkg::ERR_EMPTY, esv_pkg::POS_W'(1), esv_pkg::CH_NONE,
                              esv_pkg::CH_NONE, '0);
      end else if (fin_kind_r == esv_pkg::TK_OP) begin
        e3f = esv_pkg::mk_err(esv_pkg::ERR_OP_END, fin_ltok_pos_r, fin_ltok_ch_r,
                              esv_pkg::CH_NONE, '0);
      end
    end

    res          = '0;
    res.accepted = 1'b1;
    if (fin_err1_r.vld) begin
      res = esv_pkg::to_result(esv_pkg::LVL_CHARS, fin_err1_r);
    end else if (e2f.vld) begin
      res = esv_pkg::to_result(esv_pkg::LVL_BRACKET, e2f);
    end else if (e3f.vld) begin
      res = esv_pkg::to_result(esv_pkg::LVL_STRUCT, e3f);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qn_r <= '0;
    end else begin
      qn_r <= qn_r + 2'(fin_vld_r) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_r <= (fin_vld_r && (qn_r == 2'd1)) ? res : q1_r;
      if (fin_vld_r && (qn_r == 2'd2)) begin
        q1_r <= res;
      end
    end else if (fin_vld_r) begin
      if (qn_r == 2'd0) begin
        q0_r <= res;
      end else begin
        q1_r <= res;
      end
    end
  end

  assign out_res.valid           = (qn_r != 2'd0);
  assign out_res.accepted        = q0_r.accepted;
  assign out_res.failed_level    = q0_r.failed_level;
  assign out_res.error_code      = q0_r.error_code;
  assign out_res.position        = q0_r.position;
  assign out_res.found_char      = q0_r.found_char;
  assign out_res.expected_char   = q0_r.expected_char;
  assign out_res.opener_position = q0_r.opener_position;

endmodule

>>> hw/rtl/esv_checker.sv
// Port-level assertions of the expression syntax validator and their bind.
`include "expression_syntax_validator_assert.svh"

module esv_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_accepted,
  input logic [1:0]                out_failed_level,
  input logic [3:0]                out_error_code,
  input logic [esv_pkg::POS_W-1:0] out_position,
  input logic [esv_pkg::CH_W-1:0]  out_expected_char,
  input logic [esv_pkg::POS_W-1:0] out_opener_position
);

  // hold a stalled result
  `ESV_ASSERT(a_res_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_error_code) &&
      $stable(out_position) && $stable(out_accepted),
    "result changed while stalled")

  `ESV_ASSERT(a_accept_clean,
    out_valid && out_accepted |-> out_failed_level == esv_pkg::LVL_NONE &&
      out_error_code == esv_pkg::ERR_NONE && out_position == '0,
    "accepted result carries error fields")

  `ESV_ASSERT(a_reject_coded,
    out_valid && !out_accepted |-> out_failed_level != esv_pkg::LVL_NONE &&
      out_error_code != esv_pkg::ERR_NONE,
    "rejected result without level or code")

  `ESV_ASSERT(a_unclosed_info,
    out_valid && out_error_code == esv_pkg::ERR_UNCLOSED |->
      out_failed_level == esv_pkg::LVL_BRACKET && out_opener_position != '0 &&
      out_expected_char != esv_pkg::CH_NONE,
    "unclosed opener reported without its bracket")

  `ESV_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind expression_syntax_validator esv_checker u_esv_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_res.valid),
  .out_ready           (out_res.ready),
  .out_accepted        (out_res.accepted),
  .out_failed_level    (out_res.failed_level),
  .out_error_code      (out_res.error_code),
  .out_position        (out_res.position),
  .out_expected_char   (out_res.expected_char),
  .out_opener_position (out_res.opener_position)
);

>>> verif/tb_top.sv
// Self-checking testbench of the expression syntax validator: directed, capacity, random.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import esv_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 375;

  localparam int IDLE_PCT[4]  = '{0, 72, 0, 33};
  localparam int STALL_PCT[4] = '{0, 0, 72, 33};

  // Indexes of the three checking levels
  localparam int L_CHARS   = 0;
  localparam int L_BRACKET = 1;
  localparam int L_STRUCT  = 2;
  localparam logic [1:0] LEVEL_TAG[3] = '{LVL_CHARS, LVL_BRACKET, LVL_STRUCT};

  localparam logic [CH_W-1:0] OPENERS[3] = '{CH_LPAREN, CH_LSQ, CH_LCURLY};
  localparam logic [CH_W-1:0] CLOSERS[3] = '{CH_RPAREN, CH_RSQ, CH_RCURLY};
  localparam logic [CH_W-1:0] OPS[4]     = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  localparam logic [CH_W-1:0] WS_SET[6]  = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
  localparam logic [CH_W-1:0] SYMBOLS[10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                              CH_LPAREN, CH_LSQ, CH_LCURLY,
                                              CH_RPAREN, CH_RSQ, CH_RCURLY};

  localparam result_t CLEAN = '{accepted: 1'b1, default: '0};

  typedef struct {
    string   text;
    int      tail;      // extra byte appended after text, -1 for none
    bit      end_mark;  // close with a request that carries no character
    bit      typed;
    result_t want;
  } probe_t;

  logic clk;
  logic rst_n;

  esv_in_if  in_req ();
  esv_out_if out_res ();

  expression_syntax_validator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow of the validator state
  stk_ent_t         open_stack [STACK_DEPTH];
  int               depth_now;
  int               len_now;
  tok_kind_t        prev_kind;
  bit               seen_tok;
  bit               in_number;
  logic [POS_W-1:0] tok_pos;
  logic [CH_W-1:0]  tok_ch;
  err_rec_t         first_err [3];

  result_t          verdicts_due [$];
  logic [CH_W-1:0]  expr_buf [$];
  probe_t           dir_rows [$];
  bit               use_typed;
  result_t          typed_verdict;
  result_t          head_verdict;

  int               idle_pct;
  int               stall_pct;
  bit               hold_wanted;
  int unsigned      faults = 0;
  int unsigned      cycle_count = 0;
  int               items_sent;

  function automatic result_t flagged(logic [1:0] lvl, logic [3:0] code, int pos,
                                      logic [CH_W-1:0] found, logic [CH_W-1:0] expct,
                                      int opener);
    result_t r;
    r.accepted        = 1'b0;
    r.failed_level    = lvl;
    r.error_code      = code;
    r.position        = POS_W'(pos);
    r.found_char      = found;
    r.expected_char   = expct;
    r.opener_position = POS_W'(opener);
    return r;
  endfunction

  function automatic int family_of(logic [CH_W-1:0] c, bit closing);
    for (int k = 0; k < 3; k++) begin
      if (c == (closing ? CLOSERS[k] : OPENERS[k])) return k;
    end
    return -1;
  endfunction

  function automatic void clear_syntax();
    depth_now = 0;
    len_now   = 0;
    prev_kind = TK_NUM;
    seen_tok  = 1'b0;
    in_number = 1'b0;
    tok_pos   = '0;
    tok_ch    = '0;
    for (int l = 0; l < 3; l++) first_err[l] = '0;
  endfunction

  function automatic void note_fault(int lvl, logic [3:0] code, logic [POS_W-1:0] pos,
                                     logic [CH_W-1:0] found, logic [CH_W-1:0] expct,
                                     logic [POS_W-1:0] opener);
    if (first_err[lvl].vld) return;
    first_err[lvl].vld      = 1'b1;
    first_err[lvl].code     = code;
    first_err[lvl].pos      = pos;
    first_err[lvl].found    = found;
    first_err[lvl].expected = expct;
    first_err[lvl].opener   = opener;
  endfunction

  function automatic void take_token(tok_kind_t kind, logic [POS_W-1:0] pos,
                                     logic [CH_W-1:0] c);
    prev_kind = kind;
    seen_tok  = 1'b1;
    tok_pos   = pos;
    tok_ch    = c;
  endfunction

  // Advance the shadow state by one request; returns 1 when a verdict is due
  function automatic bit advance_syntax(logic [CH_W-1:0] c, logic hc, logic lst,
                                        output result_t verdict);
    int               ok;
    int               ck;
    bit               is_num;
    bit               is_arith;
    bit               is_blank;
    bit               done;
    logic [POS_W-1:0] pos;
    stk_ent_t         top;

    ok       = family_of(c, 1'b0);
    ck       = family_of(c, 1'b1);
    is_num   = (c >= CH_ZERO) && (c <= CH_NINE);
    is_arith = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    verdict  = CLEAN;

    if (hc) begin
      if (len_now >= MAX_LEN) begin
        note_fault(L_CHARS, ERR_CAPACITY, POS_W'(MAX_LEN + 1), c, CH_NONE, '0);
      end else begin
        len_now++;
        pos = POS_W'(len_now);
        if (!(is_num || is_arith || ok >= 0 || ck >= 0 || is_blank)) begin
          note_fault(L_CHARS, ERR_BAD_CHAR, pos, c, CH_NONE, '0);
        end
        if (!first_err[L_BRACKET].vld) begin
          if (ok >= 0) begin
            if (depth_now >= STACK_DEPTH) begin
              note_fault(L_BRACKET, ERR_CAPACITY, pos, c, CH_NONE, '0);
            end else begin
              open_stack[depth_now].kind = brk_t'(ok);
              open_stack[depth_now].pos  = pos;
              depth_now++;
            end
          end else if (ck >= 0) begin
            if (depth_now == 0) begin
              note_fault(L_BRACKET, ERR_NO_OPEN, pos, c, CH_NONE, '0);
            end else if (open_stack[depth_now-1].kind != brk_t'(ck)) begin
              note_fault(L_BRACKET, ERR_MISMATCH, pos, c,
                         CLOSERS[open_stack[depth_now-1].kind], '0);
            end else begin
              depth_now--;
            end
          end
        end
        if (!first_err[L_STRUCT].vld) begin
          if (is_num) begin
            // a digit run is one number
            if (!in_number) begin
              in_number = 1'b1;
              if (seen_tok && prev_kind == TK_NUM) begin
                note_fault(L_STRUCT, ERR_TWO_NUMS, pos, c, CH_NONE, '0);
              end else begin
                take_token(TK_NUM, pos, c);
              end
            end
          end else begin
            in_number = 1'b0;
            if (is_arith) begin
              if (!seen_tok) note_fault(L_STRUCT, ERR_OP_START, pos, c, CH_NONE, '0);
              else if (prev_kind == TK_OP) note_fault(L_STRUCT, ERR_TWO_OPS, pos, c, CH_NONE, '0);
              else if (prev_kind == TK_OPEN) note_fault(L_STRUCT, ERR_OP_OPEN, pos, c, CH_NONE, '0);
              else take_token(TK_OP, pos, c);
            end else if (ok >= 0) begin
              take_token(TK_OPEN, pos, c);
            end else if (ck >= 0) begin
              if (!seen_tok || prev_kind == TK_OP || prev_kind == TK_OPEN) begin
                note_fault(L_STRUCT, ERR_EMPTY_GRP, pos, c, CH_NONE, '0);
              end else begin
                take_token(TK_CLOSE, pos, c);
              end
            end
          end
        end
      end
    end

    if (!lst) return 1'b0;

    if (!first_err[L_BRACKET].vld && depth_now > 0) begin
      top = open_stack[depth_now-1];
      note_fault(L_BRACKET, ERR_UNCLOSED, POS_W'(len_now), CH_NONE, CLOSERS[top.kind], top.pos);
    end
    if (!first_err[L_STRUCT].vld) begin
      if (!seen_tok) note_fault(L_STRUCT, ERR_EMPTY, POS_W'(1), CH_NONE, CH_NONE, '0);
      else if (prev_kind == TK_OP) note_fault(L_STRUCT, ERR_OP_END, tok_pos, tok_ch, CH_NONE, '0);
    end

    done = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (!done && first_err[l].vld) begin
        done    = 1'b1;
        verdict = flagged(LEVEL_TAG[l], first_err[l].code, first_err[l].pos,
                          first_err[l].found, first_err[l].expected, first_err[l].opener);
      end
    end
    clear_syntax();
    return 1'b1;
  endfunction

  // Expression builders, all appending to expr_buf
  function automatic void put_ws();
    if ($urandom_range(9) == 0) expr_buf.push_back(WS_SET[$urandom_range(5)]);
  endfunction

  function automatic void put_number();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) expr_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
  endfunction

  function automatic void put_group(int nest);
    int k;
    k = $urandom_range(2);
    expr_buf.push_back(OPENERS[k]);
    put_ws();
    put_sum(nest - 1);
    expr_buf.push_back(CLOSERS[k]);
  endfunction

  // Chain of factors; a number may not follow a number directly
  function automatic void put_term(int nest);
    bit after_num;
    int n;
    n = $urandom_range(1, 3);
    after_num = 1'b0;
    for (int f = 0; f < n; f++) begin
      if (nest > 0 && (after_num || $urandom_range(2) == 0)) begin
        put_group(nest);
        after_num = 1'b0;
      end else if (!after_num) begin
        put_number();
        after_num = 1'b1;
      end
      put_ws();
    end
  endfunction

  function automatic void put_sum(int nest);
    int n;
    n = $urandom_range(0, 2);
    put_term(nest);
    repeat (n) begin
      expr_buf.push_back(OPS[$urandom_range(3)]);
      put_ws();
      put_term(nest);
    end
  endfunction

  function automatic void break_expr();
    int at;
    int pick;
    if (expr_buf.size() == 0) begin
      expr_buf.push_back(SYMBOLS[$urandom_range(9)]);
      return;
    end
    at   = $urandom_range(expr_buf.size() - 1);
    pick = $urandom_range(99);
    if (pick < 30) expr_buf[at] = 8'($urandom_range(255));
    else if (pick < 55) expr_buf.delete(at);
    else if (pick < 85) expr_buf.insert(at, SYMBOLS[$urandom_range(9)]);
    else while (expr_buf.size() > at) void'(expr_buf.pop_back());
  endfunction

  function automatic void put_noise();
    int n;
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(1)) expr_buf.push_back(8'($urandom_range(255)));
      else if ($urandom_range(1)) expr_buf.push_back(SYMBOLS[$urandom_range(9)]);
      else expr_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
  endfunction

  task automatic send(logic [CH_W-1:0] c, logic hc, logic lst);
    result_t v;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.ch       <= c;
    in_req.has_char <= hc;
    in_req.last     <= lst;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (advance_syntax(c, hc, lst, v)) verdicts_due.push_back(use_typed ? typed_verdict : v);
  endtask

  task automatic send_expr(bit end_mark);
    bit marker;
    marker = end_mark || (expr_buf.size() == 0);
    for (int k = 0; k < expr_buf.size(); k++) begin
      // sprinkle requests that carry neither a character nor an end
      if ($urandom_range(31) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
      send(expr_buf[k], 1'b1, !marker && (k == expr_buf.size() - 1));
    end
    if (marker) send(8'($urandom_range(255)), 1'b0, 1'b1);
    items_sent += expr_buf.size() + int'(marker);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result request with no expression outstanding");
        faults++;
      end else begin
        head_verdict = verdicts_due.pop_front();
        check_field("accepted", head_verdict.accepted, out_res.accepted);
        check_field("failed_level", head_verdict.failed_level, out_res.failed_level);
        check_field("error_code", head_verdict.error_code, out_res.error_code);
        check_field("position", head_verdict.position, out_res.position);
        check_field("found_char", head_verdict.found_char, out_res.found_char);
        check_field("expected_char", head_verdict.expected_char, out_res.expected_char);
        check_field("opener_position", head_verdict.opener_position, out_res.opener_position);
      end
    end
  end

  // Result side: random stalls, plus one long hold when asked
  initial begin
    int hold_left;
    hold_left     = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int kinds [$];
    int j;
    int pick;

    items_sent      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_wanted     = 1'b0;
    use_typed       = 1'b0;
    typed_verdict   = CLEAN;
    rst_n           = 1'b0;
    in_req.valid    = 1'b0;
    in_req.ch       = '0;
    in_req.has_char = 1'b0;
    in_req.last     = 1'b0;
    clear_syntax();

    dir_rows = '{
      '{"", -1, 1'b1, 1'b1, flagged(LVL_STRUCT, ERR_EMPTY, 1, CH_NONE, CH_NONE, 0)},
      '{"7", -1, 1'b0, 1'b1, CLEAN},
      '{"12+3-4*5/6", -1, 1'b0, 1'b1, CLEAN},
      '{"(1)[2]{3}", -1, 1'b0, 1'b1, CLEAN},
      '{"2(3)4", -1, 1'b0, 1'b1, CLEAN},
      '{" \t1\n\013+\014 2\015", -1, 1'b0, 1'b1, CLEAN},
      '{"1 2", -1, 1'b0, 1'b1, flagged(LVL_STRUCT, ERR_TWO_NUMS, 3, "2", CH_NONE, 0)},
      '{"+1", -1, 1'b0, 1'b1, flagged(LVL_STRUCT, ERR_OP_START, 1, CH_PLUS, CH_NONE, 0)},
      '{"1+*2", -1, 1'b0, 1'b1, flagged(LVL_STRUCT, ERR_TWO_OPS, 3, CH_STAR, CH_NONE, 0)},
      '{"(-1)", -1, 1'b0, 1'b1, flagged(LVL_STRUCT, ERR_OP_OPEN, 2, CH_MINUS, CH_NONE, 0)},
      '{"()", -1, 1'b0, 1'b1, flagged(LVL_STRUCT, ERR_EMPTY_GRP, 2, CH_RPAREN, CH_NONE, 0)},
      '{"1-", -1, 1'b0, 1'b1, flagged(LVL_STRUCT, ERR_OP_END, 2, CH_MINUS, CH_NONE, 0)},
      '{"1)", -1, 1'b0, 1'b1, flagged(LVL_BRACKET, ERR_NO_OPEN, 2, CH_RPAREN, CH_NONE, 0)},
      '{"(1]", -1, 1'b0, 1'b1, flagged(LVL_BRACKET, ERR_MISMATCH, 3, CH_RSQ, CH_RPAREN, 0)},
      '{"{[(1)]", -1, 1'b0, 1'b1, flagged(LVL_BRACKET, ERR_UNCLOSED, 6, CH_NONE, CH_RCURLY, 1)},
      '{"(1", -1, 1'b1, 1'b1, flagged(LVL_BRACKET, ERR_UNCLOSED, 2, CH_NONE, CH_RPAREN, 1)},
      '{"1a", -1, 1'b0, 1'b1, flagged(LVL_CHARS, ERR_BAD_CHAR, 2, "a", CH_NONE, 0)},
      '{"a)", -1, 1'b0, 1'b1, flagged(LVL_CHARS, ERR_BAD_CHAR, 1, "a", CH_NONE, 0)},
      '{"1", 8'h00, 1'b0, 1'b1, flagged(LVL_CHARS, ERR_BAD_CHAR, 2, CH_NONE, CH_NONE, 0)},
      '{"", 8'hFF, 1'b0, 1'b1, flagged(LVL_CHARS, ERR_BAD_CHAR, 1, 8'hFF, CH_NONE, 0)},
      '{"8*", -1, 1'b1, 1'b0, CLEAN},
      '{"9)(", -1, 1'b0, 1'b0, CLEAN},
      '{"0 09", -1, 1'b0, 1'b0, CLEAN},
      '{"1//2)+", -1, 1'b0, 1'b0, CLEAN},
      '{"{2}(3)[4]5", -1, 1'b0, 1'b0, CLEAN}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      expr_buf.delete();
      for (int k = 0; k < dir_rows[i].text.len(); k++) expr_buf.push_back(dir_rows[i].text[k]);
      if (dir_rows[i].tail >= 0) expr_buf.push_back(8'(dir_rows[i].tail));
      use_typed     = dir_rows[i].typed;
      typed_verdict = dir_rows[i].want;
      send_expr(dir_rows[i].end_mark);
    end
    use_typed = 1'b0;

    // Nesting exactly at the stack depth, then one opener beyond it
    for (int extra = 0; extra < 2; extra++) begin
      expr_buf.delete();
      kinds.delete();
      for (int k = 0; k < STACK_DEPTH + extra; k++) begin
        j = $urandom_range(2);
        kinds.push_back(j);
        expr_buf.push_back(OPENERS[j]);
      end
      expr_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      while (kinds.size() != 0) expr_buf.push_back(CLOSERS[kinds.pop_back()]);
      send_expr(1'b0);
    end

    // Length up to the limit and past it, closed by a character beyond it
    expr_buf.delete();
    for (int k = 0; k < MAX_LEN; k++) begin
      if (k % 2 == 1 && k != MAX_LEN - 1) expr_buf.push_back(OPS[$urandom_range(3)]);
      else expr_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
    repeat (2) expr_buf.push_back(8'($urandom_range(255)));
    send_expr(1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct   = IDLE_PCT[ph];
      stall_pct  = STALL_PCT[ph];
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        expr_buf.delete();
        pick = $urandom_range(99);
        if (pick < 85) begin
          put_ws();
          put_sum($urandom_range(0, 2));
          if (pick >= 65) break_expr();
        end else begin
          put_noise();
        end
        send_expr($urandom_range(99) < 15);
      end
    end

    // Hold the result side off while short expressions keep coming
    idle_pct    = 0;
    stall_pct   = 0;
    hold_wanted = 1'b1;
    repeat (40) begin
      expr_buf.delete();
      put_number();
      send_expr(1'b0);
    end

    in_req.valid <= 1'b0;
    stall_pct = 33;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
